>>> src/dll_pkg.sv
// Package for the doubly linked list with cursor: operation codes, status codes,
// sequencer states and default sizes. No dependencies.
package dll_pkg;

    localparam int NODES_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int VALUE_W        = 32;
    localparam int OP_W           = 5;
    localparam int STATUS_W       = 2;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR      = 5'd0,
        OP_INS_HEAD   = 5'd1,
        OP_INS_TAIL   = 5'd2,
        OP_CUR_HEAD   = 5'd3,
        OP_CUR_TAIL   = 5'd4,
        OP_RD_HEAD    = 5'd5,
        OP_RD_TAIL    = 5'd6,
        OP_DEL_HEAD   = 5'd7,
        OP_DEL_TAIL   = 5'd8,
        OP_DEL_AFTER  = 5'd9,
        OP_DEL_BEFORE = 5'd10,
        OP_INS_AFTER  = 5'd11,
        OP_INS_BEFORE = 5'd12,
        OP_RD_CUR     = 5'd13,
        OP_WR_CUR     = 5'd14,
        OP_NEXT       = 5'd15,
        OP_PREV       = 5'd16
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NO_CURSOR = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_WR1,
        S_WR2
    } state_t;

endpackage

>>> src/dll_ram.sv
// Simple dual-port RAM for the list: one write port, one read port with
// registered read data. No dependencies.
module dll_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> src/doubly_linked_list_with_cursor_core.sv
// Top level of the doubly linked list with cursor: sequencer, list pointers and
// the three node memories. Depends on dll_pkg and dll_ram.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item: an operation code and a
//   data word. Output channel (out_valid/out_ready) returns exactly one result
//   item per input item: read word, status, cursor flag and empty flag.
//   An accepted item steps through RD1, RD2, WR1 and WR2; its result is loaded
//   into the output register at the commit in WR2. Each item runs two read
//   rounds on the link memories (a link read may depend on the one before it)
//   and two write rounds, since each memory has a single write port and an
//   item can rewrite up to two entries of the same link memory.
//   The next item is accepted in the cycle its predecessor's result is loaded
//   into the output register, so one result may wait while the next item runs.
//   When the receiver stalls, the finished item holds in its last step until
//   the output register frees up, and no new item is accepted meanwhile.
//   Reset empties the list, drops the cursor and marks the whole pool unused;
//   node memories need no clearing pass, since an entry is always written
//   before it is read.
module doubly_linked_list_with_cursor_core #(
    parameter int NODES      = dll_pkg::NODES_DEF,
    parameter int DATA_WIDTH = dll_pkg::DATA_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [dll_pkg::OP_W-1:0]            op,
    input  logic signed [dll_pkg::VALUE_W-1:0]  value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [dll_pkg::VALUE_W-1:0]  read_value,
    output logic [dll_pkg::STATUS_W-1:0]        status,
    output logic                                cursor_valid,
    output logic                                list_empty
);

    import dll_pkg::*;

    // Node pointers carry one extra code: NODES stands for null.
    localparam int IDX_W = $clog2(NODES);
    localparam int PTR_W = $clog2(NODES + 1);
    localparam logic [PTR_W-1:0] NIL = PTR_W'(NODES);

    // Sequencer and list registers
    state_t                 state_reg, state_next;
    op_t                    op_reg;
    logic [DATA_WIDTH-1:0]  value_reg;
    logic [PTR_W-1:0]       head_reg, head_next;
    logic [PTR_W-1:0]       tail_reg, tail_next;
    logic [PTR_W-1:0]       cur_reg, cur_next;
    logic [PTR_W-1:0]       free_reg, free_next;
    logic [PTR_W-1:0]       fresh_reg, fresh_next;

    // Links and data captured from the read rounds
    logic [PTR_W-1:0]       nx1_reg, pv1_reg, nx2_reg, pv2_reg;
    logic [DATA_WIDTH-1:0]  val_reg;

    // Output register
    logic                   out_valid_reg;
    logic [VALUE_W-1:0]     read_value_reg, read_value_next;
    status_t                status_reg, status_next;
    logic                   cursor_valid_reg, list_empty_reg;

    // Memory ports
    logic                   nx_we, pv_we, val_we;
    logic [PTR_W-1:0]       nx_waddr, pv_waddr, val_waddr;
    logic [PTR_W-1:0]       nx_wdata, pv_wdata;
    logic [PTR_W-1:0]       nx_raddr, pv_raddr, val_raddr;
    logic [PTR_W-1:0]       nx_q, pv_q;
    logic [DATA_WIDTH-1:0]  val_q;

    // Derived conditions
    logic                   slot_free, commit, accept;
    logic                   full, has_head, has_cur, single;
    logic                   ins_ok, del_after_ok, del_before_ok;
    logic [PTR_W-1:0]       new_node;

    assign slot_free = !out_valid_reg || out_ready;
    assign commit    = (state_reg == S_WR2) && slot_free;
    assign in_ready  = (state_reg == S_IDLE) || commit;
    assign accept    = in_valid && in_ready;

    // Take a node from the free chain first, then from the unused part of the pool.
    assign full     = (free_reg == NIL) && (fresh_reg == NIL);
    assign new_node = (free_reg != NIL) ? free_reg : fresh_reg;
    assign has_head = (head_reg != NIL);
    assign has_cur  = (cur_reg != NIL);
    assign single   = (head_reg == tail_reg);

    // Insert at head or tail needs a free node; inserts at the cursor also need the cursor.
    assign ins_ok        = !full && (has_cur || op_reg == OP_INS_HEAD || op_reg == OP_INS_TAIL);
    assign del_after_ok  = has_cur && (nx1_reg != NIL);
    assign del_before_ok = has_cur && (pv1_reg != NIL);

    //--------------------------------------------------------------------------
    // Node memories
    //--------------------------------------------------------------------------
    dll_ram #(.DEPTH(NODES), .WIDTH(PTR_W)) u_next_ram (
        .clk   (clk),
        .we    (nx_we),
        .waddr (nx_waddr[IDX_W-1:0]),
        .wdata (nx_wdata),
        .raddr (nx_raddr[IDX_W-1:0]),
        .rdata (nx_q)
    );

    dll_ram #(.DEPTH(NODES), .WIDTH(PTR_W)) u_prev_ram (
        .clk   (clk),
        .we    (pv_we),
        .waddr (pv_waddr[IDX_W-1:0]),
        .wdata (pv_wdata),
        .raddr (pv_raddr[IDX_W-1:0]),
        .rdata (pv_q)
    );

    dll_ram #(.DEPTH(NODES), .WIDTH(DATA_WIDTH)) u_value_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr[IDX_W-1:0]),
        .wdata (value_reg),
        .raddr (val_raddr[IDX_W-1:0]),
        .rdata (val_q)
    );

    //--------------------------------------------------------------------------
    // Sequencer: IDLE -> RD1 -> RD2 -> WR1 -> WR2 (commit) -> RD1 or IDLE
    //--------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_RD1;
                end
            end
            S_RD1: state_next = S_RD2;
            S_RD2: state_next = S_WR1;
            S_WR1: state_next = S_WR2;
            S_WR2:
            begin
                // Hold here while the previous result is still waiting.
                if (slot_free)
                begin
                    state_next = in_valid ? S_RD1 : S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    //--------------------------------------------------------------------------
    // Read addresses. The first round reads links of the list registers; the
    // second round follows a link read in the first (nx_q/pv_q hold it now).
    //--------------------------------------------------------------------------
    always_comb
    begin
        nx_raddr  = cur_reg;
        pv_raddr  = cur_reg;
        val_raddr = cur_reg;
        if (state_reg == S_RD1)
        begin
            unique case (op_reg)
                OP_INS_HEAD, OP_INS_TAIL, OP_INS_AFTER, OP_INS_BEFORE: nx_raddr = free_reg;
                OP_DEL_HEAD: nx_raddr = head_reg;
                OP_DEL_TAIL: pv_raddr = tail_reg;
                OP_RD_HEAD:  val_raddr = head_reg;
                OP_RD_TAIL:  val_raddr = tail_reg;
                default:     nx_raddr = cur_reg;
            endcase
        end
        else if (state_reg == S_RD2)
        begin
            unique case (op_reg)
                OP_DEL_AFTER:  nx_raddr = nx_q;
                OP_DEL_BEFORE: pv_raddr = pv_q;
                default:       nx_raddr = cur_reg;
            endcase
        end
    end

    // Capture read rounds; latch the item on accept.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op_t'(op);
            value_reg <= DATA_WIDTH'(value);
        end
        if (state_reg == S_RD2)
        begin
            nx1_reg <= nx_q;
            pv1_reg <= pv_q;
            val_reg <= val_q;
        end
        if (state_reg == S_WR1)
        begin
            nx2_reg <= nx_q;
            pv2_reg <= pv_q;
        end
    end

    //--------------------------------------------------------------------------
    // Write rounds. Each memory takes at most one write per round. Reads of the
    // next item start only after the last write round, so no forwarding is needed.
    //--------------------------------------------------------------------------
    always_comb
    begin
        nx_we     = 1'b0;
        pv_we     = 1'b0;
        val_we    = 1'b0;
        nx_waddr  = new_node;
        pv_waddr  = new_node;
        val_waddr = new_node;
        nx_wdata  = NIL;
        pv_wdata  = NIL;
        if (state_reg == S_WR1)
        begin
            unique case (op_reg)
                OP_INS_HEAD:
                begin
                    val_we   = ins_ok;
                    nx_we    = ins_ok;
                    nx_wdata = head_reg;
                    pv_we    = ins_ok;
                end
                OP_INS_TAIL:
                begin
                    val_we   = ins_ok;
                    nx_we    = ins_ok;
                    pv_we    = ins_ok;
                    pv_wdata = tail_reg;
                end
                OP_DEL_HEAD:
                begin
                    pv_we    = has_head && !single;
                    pv_waddr = nx1_reg;
                end
                OP_DEL_TAIL:
                begin
                    nx_we    = has_head && !single;
                    nx_waddr = pv1_reg;
                end
                OP_DEL_AFTER:
                begin
                    nx_we    = del_after_ok;
                    nx_waddr = cur_reg;
                    nx_wdata = nx_q;
                end
                OP_DEL_BEFORE:
                begin
                    pv_we    = del_before_ok;
                    pv_waddr = cur_reg;
                    pv_wdata = pv_q;
                    // Push the dropped node onto the free chain.
                    nx_we    = del_before_ok;
                    nx_waddr = pv1_reg;
                    nx_wdata = free_reg;
                end
                OP_INS_AFTER:
                begin
                    val_we   = ins_ok;
                    nx_we    = ins_ok;
                    nx_wdata = nx_q;
                    pv_we    = ins_ok;
                    pv_wdata = cur_reg;
                end
                OP_INS_BEFORE:
                begin
                    val_we   = ins_ok;
                    pv_we    = ins_ok;
                    pv_wdata = pv1_reg;
                    nx_we    = ins_ok;
                    nx_wdata = cur_reg;
                end
                OP_WR_CUR:
                begin
                    val_we    = has_cur;
                    val_waddr = cur_reg;
                end
                default:
                begin
                    val_we = 1'b0;
                end
            endcase
        end
        else if (state_reg == S_WR2)
        begin
            unique case (op_reg)
                OP_INS_HEAD:
                begin
                    pv_we    = ins_ok && has_head;
                    pv_waddr = head_reg;
                    pv_wdata = new_node;
                end
                OP_INS_TAIL:
                begin
                    nx_we    = ins_ok && has_head;
                    nx_waddr = tail_reg;
                    nx_wdata = new_node;
                end
                OP_DEL_HEAD:
                begin
                    nx_we    = has_head;
                    nx_waddr = head_reg;
                    nx_wdata = free_reg;
                end
                OP_DEL_TAIL:
                begin
                    nx_we    = has_head;
                    nx_waddr = tail_reg;
                    nx_wdata = free_reg;
                end
                OP_DEL_AFTER:
                begin
                    nx_we    = del_after_ok;
                    nx_waddr = nx1_reg;
                    nx_wdata = free_reg;
                    pv_we    = del_after_ok && (nx1_reg != tail_reg);
                    pv_waddr = nx2_reg;
                    pv_wdata = cur_reg;
                end
                OP_DEL_BEFORE:
                begin
                    nx_we    = del_before_ok && (pv1_reg != head_reg);
                    nx_waddr = pv2_reg;
                    nx_wdata = cur_reg;
                end
                OP_INS_AFTER:
                begin
                    nx_we    = ins_ok;
                    nx_waddr = cur_reg;
                    nx_wdata = new_node;
                    pv_we    = ins_ok && (cur_reg != tail_reg);
                    pv_waddr = nx2_reg;
                    pv_wdata = new_node;
                end
                OP_INS_BEFORE:
                begin
                    pv_we    = ins_ok;
                    pv_waddr = cur_reg;
                    pv_wdata = new_node;
                    nx_we    = ins_ok && (cur_reg != head_reg);
                    nx_waddr = pv1_reg;
                    nx_wdata = new_node;
                end
                default:
                begin
                    nx_we = 1'b0;
                end
            endcase
        end
    end

    //--------------------------------------------------------------------------
    // Commit: list registers and result, taken when the item finishes.
    //--------------------------------------------------------------------------
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        cur_next        = cur_reg;
        free_next       = free_reg;
        fresh_next      = fresh_reg;
        status_next     = ST_OK;
        read_value_next = '0;

        // Every successful insert consumes the node it was handed.
        if (ins_ok && (op_reg == OP_INS_HEAD || op_reg == OP_INS_TAIL ||
                       op_reg == OP_INS_AFTER || op_reg == OP_INS_BEFORE))
        begin
            if (free_reg != NIL)
            begin
                free_next = nx1_reg;
            end
            else
            begin
                fresh_next = fresh_reg + PTR_W'(1);
            end
        end

        unique case (op_reg)
            OP_CLEAR:
            begin
                head_next  = NIL;
                tail_next  = NIL;
                cur_next   = NIL;
                free_next  = NIL;
                fresh_next = '0;
            end
            OP_INS_HEAD:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    head_next = new_node;
                    if (!has_head)
                    begin
                        tail_next = new_node;
                    end
                end
            end
            OP_INS_TAIL:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    tail_next = new_node;
                    if (!has_head)
                    begin
                        head_next = new_node;
                    end
                end
            end
            OP_CUR_HEAD: cur_next = head_reg;
            OP_CUR_TAIL: cur_next = tail_reg;
            OP_RD_HEAD, OP_RD_TAIL:
            begin
                if (has_head)
                begin
                    read_value_next = VALUE_W'($signed(val_reg));
                end
                else
                begin
                    status_next = ST_EMPTY;
                end
            end
            OP_DEL_HEAD:
            begin
                if (has_head)
                begin
                    if (cur_reg == head_reg)
                    begin
                        cur_next = NIL;
                    end
                    if (single)
                    begin
                        head_next = NIL;
                        tail_next = NIL;
                    end
                    else
                    begin
                        head_next = nx1_reg;
                    end
                    free_next = head_reg;
                end
            end
            OP_DEL_TAIL:
            begin
                if (has_head)
                begin
                    if (cur_reg == tail_reg)
                    begin
                        cur_next = NIL;
                    end
                    if (single)
                    begin
                        head_next = NIL;
                        tail_next = NIL;
                    end
                    else
                    begin
                        tail_next = pv1_reg;
                    end
                    free_next = tail_reg;
                end
            end
            OP_DEL_AFTER:
            begin
                if (del_after_ok)
                begin
                    if (nx1_reg == tail_reg)
                    begin
                        tail_next = cur_reg;
                    end
                    free_next = nx1_reg;
                end
            end
            OP_DEL_BEFORE:
            begin
                if (del_before_ok)
                begin
                    if (pv1_reg == head_reg)
                    begin
                        head_next = cur_reg;
                    end
                    free_next = pv1_reg;
                end
            end
            OP_INS_AFTER:
            begin
                if (has_cur && full)
                begin
                    status_next = ST_FULL;
                end
                else if (ins_ok && cur_reg == tail_reg)
                begin
                    tail_next = new_node;
                end
            end
            OP_INS_BEFORE:
            begin
                if (has_cur && full)
                begin
                    status_next = ST_FULL;
                end
                else if (ins_ok && cur_reg == head_reg)
                begin
                    head_next = new_node;
                end
            end
            OP_RD_CUR:
            begin
                if (has_cur)
                begin
                    read_value_next = VALUE_W'($signed(val_reg));
                end
                else
                begin
                    status_next = ST_NO_CURSOR;
                end
            end
            OP_NEXT:
            begin
                if (has_cur)
                begin
                    cur_next = nx1_reg;
                end
            end
            OP_PREV:
            begin
                if (has_cur)
                begin
                    cur_next = pv1_reg;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= NIL;
            tail_reg      <= NIL;
            cur_reg       <= NIL;
            free_reg      <= NIL;
            fresh_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (commit)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                cur_reg   <= cur_next;
                free_reg  <= free_next;
                fresh_reg <= fresh_next;
            end
            // Load on commit, drop once the receiver takes it.
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            read_value_reg   <= read_value_next;
            status_reg       <= status_next;
            cursor_valid_reg <= (cur_next != NIL);
            list_empty_reg   <= (head_next == NIL);
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_value   = $signed(read_value_reg);
    assign status       = status_reg;
    assign cursor_valid = cursor_valid_reg;
    assign list_empty   = list_empty_reg;

`ifndef NO_ASSERTIONS
    // Head and tail are null together.
    a_ends_agree: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == NIL) == (tail_reg == NIL))
        else $error("head and tail disagree on an empty list");

    // An empty list never keeps a cursor.
    a_cursor_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg == NIL) |-> (cur_reg == NIL))
        else $error("cursor set on an empty list");

    // The unused-pool counter never passes the pool size.
    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= NIL)
        else $error("fresh node count out of range");

    // A result is loaded only while the output register is free or being taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(status_reg)))
        else $error("pending result overwritten");
`endif

endmodule

>>> tb/tb_list_checker.sv
// Checker for the doubly linked list core: keeps its own copy of the node pool,
// predicts one result per accepted item and compares it with the result channel.
// Depends on dll_pkg.
module tb_list_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [dll_pkg::OP_W-1:0]            op,
    input  logic signed [dll_pkg::VALUE_W-1:0]  value,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [dll_pkg::VALUE_W-1:0]  read_value,
    input  logic [dll_pkg::STATUS_W-1:0]        status,
    input  logic                                cursor_valid,
    input  logic                                list_empty,
    output int                                  fail_count,
    output int                                  results_due
);
    import dll_pkg::*;

    localparam int POOL         = NODES_DEF;
    localparam int LINK_W       = $clog2(POOL + 1);
    localparam int REPORT_LIMIT = 10;

    typedef logic [LINK_W-1:0] link_t;

    localparam link_t NIL = link_t'(POOL);

    typedef struct packed {
        logic [VALUE_W-1:0] word;
        status_t            code;
        logic               has_cursor;
        logic               empty;
    } list_result_t;

    typedef struct packed {
        logic [OP_W-1:0] op_code;
        list_result_t    res;
    } pending_t;

    // shadow of the list
    logic [VALUE_W-1:0] word_mem  [POOL];
    link_t              fwd_link  [POOL];
    link_t              back_link [POOL];
    link_t              head_q, tail_q, cur_q, spare_head, unused_next;

    pending_t           result_q [$];

    function automatic link_t fwd_of(link_t i);
        return (i < NIL) ? fwd_link[i] : NIL;
    endfunction

    function automatic link_t back_of(link_t i);
        return (i < NIL) ? back_link[i] : NIL;
    endfunction

    function automatic void set_fwd(link_t i, link_t v);
        if (i < NIL)
        begin
            fwd_link[i] = v;
        end
    endfunction

    function automatic void set_back(link_t i, link_t v);
        if (i < NIL)
        begin
            back_link[i] = v;
        end
    endfunction

    // Take from the freed chain first, then from the never-used part of the pool.
    function automatic link_t take_node();
        link_t n;
        if (spare_head != NIL)
        begin
            n = spare_head;
            spare_head = fwd_of(n);
        end
        else if (unused_next < NIL)
        begin
            n = unused_next;
            unused_next = unused_next + link_t'(1);
        end
        else
        begin
            n = NIL;
        end
        return n;
    endfunction

    function automatic void release_node(link_t d);
        set_fwd(d, spare_head);
        spare_head = d;
    endfunction

    // Apply one operation to the shadow list and return the result it should give.
    function automatic list_result_t apply_op(logic [OP_W-1:0] code, logic [VALUE_W-1:0] word);
        list_result_t r;
        link_t        n;
        link_t        d;
        link_t        c;
        r = '{word: '0, code: ST_OK, has_cursor: 1'b0, empty: 1'b0};
        c = cur_q;
        case (code)
            OP_CLEAR:
            begin
                head_q      = NIL;
                tail_q      = NIL;
                cur_q       = NIL;
                spare_head  = NIL;
                unused_next = '0;
            end
            OP_INS_HEAD:
            begin
                n = take_node();
                if (n == NIL)
                begin
                    r.code = ST_FULL;
                end
                else
                begin
                    word_mem[n] = word;
                    set_fwd(n, head_q);
                    set_back(n, NIL);
                    if (head_q != NIL) set_back(head_q, n);
                    else tail_q = n;
                    head_q = n;
                end
            end
            OP_INS_TAIL:
            begin
                n = take_node();
                if (n == NIL)
                begin
                    r.code = ST_FULL;
                end
                else
                begin
                    word_mem[n] = word;
                    set_fwd(n, NIL);
                    set_back(n, tail_q);
                    if (tail_q != NIL) set_fwd(tail_q, n);
                    else head_q = n;
                    tail_q = n;
                end
            end
            OP_CUR_HEAD: cur_q = head_q;
            OP_CUR_TAIL: cur_q = tail_q;
            OP_RD_HEAD:
            begin
                if (head_q == NIL) r.code = ST_EMPTY;
                else r.word = word_mem[head_q];
            end
            OP_RD_TAIL:
            begin
                if (tail_q == NIL) r.code = ST_EMPTY;
                else r.word = word_mem[tail_q];
            end
            OP_DEL_HEAD:
            begin
                if (head_q != NIL)
                begin
                    d = head_q;
                    if (cur_q == d) cur_q = NIL;
                    if (head_q == tail_q)
                    begin
                        head_q = NIL;
                        tail_q = NIL;
                    end
                    else
                    begin
                        head_q = fwd_of(d);
                        set_back(head_q, NIL);
                    end
                    release_node(d);
                end
            end
            OP_DEL_TAIL:
            begin
                if (tail_q != NIL)
                begin
                    d = tail_q;
                    if (cur_q == d) cur_q = NIL;
                    if (head_q == tail_q)
                    begin
                        head_q = NIL;
                        tail_q = NIL;
                    end
                    else
                    begin
                        tail_q = back_of(d);
                        set_fwd(tail_q, NIL);
                    end
                    release_node(d);
                end
            end
            OP_DEL_AFTER:
            begin
                if (c != NIL && fwd_of(c) != NIL)
                begin
                    d = fwd_of(c);
                    set_fwd(c, fwd_of(d));
                    if (d == tail_q) tail_q = c;
                    else set_back(fwd_of(d), c);
                    release_node(d);
                end
            end
            OP_DEL_BEFORE:
            begin
                if (c != NIL && back_of(c) != NIL)
                begin
                    d = back_of(c);
                    set_back(c, back_of(d));
                    if (d == head_q) head_q = c;
                    else set_fwd(back_of(d), c);
                    release_node(d);
                end
            end
            OP_INS_AFTER:
            begin
                if (c != NIL)
                begin
                    n = take_node();
                    if (n == NIL)
                    begin
                        r.code = ST_FULL;
                    end
                    else
                    begin
                        word_mem[n] = word;
                        set_fwd(n, fwd_of(c));
                        set_back(n, c);
                        set_fwd(c, n);
                        if (c == tail_q) tail_q = n;
                        else set_back(fwd_of(n), n);
                    end
                end
            end
            OP_INS_BEFORE:
            begin
                if (c != NIL)
                begin
                    n = take_node();
                    if (n == NIL)
                    begin
                        r.code = ST_FULL;
                    end
                    else
                    begin
                        word_mem[n] = word;
                        set_back(n, back_of(c));
                        set_fwd(n, c);
                        set_back(c, n);
                        if (c == head_q) head_q = n;
                        else set_fwd(back_of(n), n);
                    end
                end
            end
            OP_RD_CUR:
            begin
                if (c == NIL) r.code = ST_NO_CURSOR;
                else r.word = word_mem[c];
            end
            OP_WR_CUR:
            begin
                if (c != NIL) word_mem[c] = word;
            end
            OP_NEXT:
            begin
                if (c != NIL) cur_q = fwd_of(c);
            end
            OP_PREV:
            begin
                if (c != NIL) cur_q = back_of(c);
            end
            default: ;
        endcase
        r.has_cursor = (cur_q != NIL);
        r.empty      = (head_q == NIL);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pending_t     want;
        list_result_t got;
        if (!rst_n)
        begin
            head_q      = NIL;
            tail_q      = NIL;
            cur_q       = NIL;
            spare_head  = NIL;
            unused_next = '0;
            result_q.delete();
            fail_count  = 0;
            results_due = 0;
        end
        else
        begin
            // compare a delivered result with the oldest prediction
            if (out_valid && out_ready)
            begin
                got = '{word: read_value, code: status_t'(status),
                        has_cursor: cursor_valid, empty: list_empty};
                if (result_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("tb_list_checker: result with nothing pending: rd=%0d st=%0d",
                                 $signed(got.word), got.code);
                end
                else
                begin
                    want = result_q.pop_front();
                    if (got.word !== want.res.word || got.code !== want.res.code ||
                        got.has_cursor !== want.res.has_cursor ||
                        got.empty !== want.res.empty)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                        begin
                            $write("tb_list_checker: op %0d expected rd=%0d st=%0d cur=%0d ",
                                   want.op_code, $signed(want.res.word), want.res.code,
                                   want.res.has_cursor);
                            $display("empty=%0d, got rd=%0d st=%0d cur=%0d empty=%0d",
                                     want.res.empty, $signed(got.word), got.code,
                                     got.has_cursor, got.empty);
                        end
                    end
                end
            end
            // predict the result of a newly accepted item
            if (in_valid && in_ready)
            begin
                want.op_code = op;
                want.res     = apply_op(op, value);
                result_q.push_back(want);
            end
            results_due = result_q.size();
        end
    end

endmodule

>>> tb/tb_top.sv
// Testbench top for doubly_linked_list_with_cursor_core: clock, reset, item
// stimulus with bursty sending and a stalling receiver, and the verdict.
// Depends on dll_pkg, the core and tb_list_checker.
module tb_top;
    import dll_pkg::*;

    localparam int PERIOD       = 8;
    localparam int RESET_CYCLES = 4;
    localparam int RANDOM_ITEMS = 1650;
    localparam int CYCLE_LIMIT  = 200000;
    // extra time to wait after the last predicted result has come back
    localparam int DRAIN_CYCLES = 16;

    // op codes the block treats as no operation
    localparam logic [OP_W-1:0] OP_SPARE_LO = 5'd17;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 5'd31;

    typedef enum int { MIX_GROW, MIX_SHRINK, MIX_WALK, MIX_NOISE } mix_t;
    typedef enum int { RX_OPEN, RX_COIN, RX_SLOW, RX_MOSTLY } rx_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [OP_W-1:0]            op = '0;
    logic signed [VALUE_W-1:0]  value = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [VALUE_W-1:0]  read_value;
    logic [STATUS_W-1:0]        status;
    logic                       cursor_valid;
    logic                       list_empty;
    int                         fail_count;
    int                         results_due;

    int                         cycles = 0;
    int                         burst_left = 0;
    rx_t                        rx_mode = RX_OPEN;
    int                         rx_left = 0;
    int                         rx_phase = 0;

    always #(PERIOD / 2) clk = ~clk;

    doubly_linked_list_with_cursor_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_value   (read_value),
        .status       (status),
        .cursor_valid (cursor_valid),
        .list_empty   (list_empty)
    );

    tb_list_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_value   (read_value),
        .status       (status),
        .cursor_valid (cursor_valid),
        .list_empty   (list_empty),
        .fail_count   (fail_count),
        .results_due  (results_due)
    );

    // Watchdog: stop a hung run long after the slowest legal run would finish.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Receiver: switch between stall patterns, from always ready through a coin
    // flip and mostly ready down to a slow one, so stalls hit every step of the
    // core's sequence and sometimes leave a result waiting behind the next one.
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_t'($urandom_range(RX_OPEN, RX_MOSTLY));
            rx_left = $urandom_range(20, 300);
        end
        rx_left--;
        rx_phase++;
        case (rx_mode)
            RX_OPEN:   out_ready = 1'b1;
            RX_COIN:   out_ready = ($urandom_range(0, 1) == 1);
            RX_SLOW:   out_ready = (rx_phase % 9 == 0);
            default:   out_ready = ($urandom_range(0, 4) != 0);
        endcase
    end

    // Present one item at the falling edge and hold it until the core takes it.
    // Leave valid high while a burst lasts; otherwise drop it for a random gap.
    task automatic send(input logic [OP_W-1:0] code, input logic [VALUE_W-1:0] word);
        int gap;
        in_valid = 1'b1;
        op       = code;
        value    = word;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 7);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 15);
        end
    endtask

    // Hold off the sender until every predicted result has come back.
    task automatic wait_quiet();
        in_valid = 1'b0;
        while (results_due != 0) @(negedge clk);
    endtask

    // Data word: favor the extremes, otherwise a full random word.
    function automatic logic [VALUE_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_either(logic [OP_W-1:0] a, logic [OP_W-1:0] b);
        return ($urandom_range(0, 1) == 1) ? a : b;
    endfunction

    // Operation mix per phase. Growing phases fill the pool until inserts
    // bounce; shrinking phases drain it back onto the free chain; walking
    // phases move the cursor around; noise takes any 5-bit code, clear and
    // the unused codes included.
    function automatic logic [OP_W-1:0] pick_op(mix_t mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_GROW:
            begin
                if (r < 25) return OP_INS_HEAD;
                if (r < 50) return OP_INS_TAIL;
                if (r < 62) return OP_INS_AFTER;
                if (r < 74) return OP_INS_BEFORE;
                if (r < 80) return pick_either(OP_CUR_HEAD, OP_CUR_TAIL);
                if (r < 86) return pick_either(OP_NEXT, OP_PREV);
                if (r < 92) return pick_either(pick_either(OP_DEL_HEAD, OP_DEL_TAIL),
                                               pick_either(OP_DEL_AFTER, OP_DEL_BEFORE));
                return pick_either(pick_either(OP_RD_HEAD, OP_RD_TAIL), OP_RD_CUR);
            end
            MIX_SHRINK:
            begin
                if (r < 15) return OP_DEL_HEAD;
                if (r < 30) return OP_DEL_TAIL;
                if (r < 45) return OP_DEL_AFTER;
                if (r < 60) return OP_DEL_BEFORE;
                if (r < 70) return pick_either(OP_CUR_HEAD, OP_CUR_TAIL);
                if (r < 80) return pick_either(OP_NEXT, OP_PREV);
                if (r < 88) return pick_either(pick_either(OP_INS_HEAD, OP_INS_TAIL),
                                               pick_either(OP_INS_AFTER, OP_INS_BEFORE));
                return pick_either(pick_either(OP_RD_HEAD, OP_RD_TAIL),
                                   pick_either(OP_RD_CUR, OP_WR_CUR));
            end
            MIX_WALK:
            begin
                if (r < 15) return pick_either(OP_CUR_HEAD, OP_CUR_TAIL);
                if (r < 45) return pick_either(OP_NEXT, OP_PREV);
                if (r < 60) return OP_RD_CUR;
                if (r < 70) return OP_WR_CUR;
                if (r < 80) return pick_either(OP_RD_HEAD, OP_RD_TAIL);
                if (r < 90) return pick_either(OP_DEL_AFTER, OP_DEL_BEFORE);
                return pick_either(OP_INS_AFTER, OP_INS_BEFORE);
            end
            default: return OP_W'($urandom_range(0, 2 ** OP_W - 1));
        endcase
    endfunction

    // Short directed run: empty-list reads and deletes, operations without a
    // cursor, extreme words, cursor inserts at the ends, the cursor running
    // off either end, deleting the cursor node, unused codes and clear.
    task automatic run_directed();
        send(OP_RD_HEAD, '0);
        send(OP_RD_CUR, '0);
        send(OP_DEL_TAIL, '0);
        send(OP_INS_AFTER, 32'h0000_1234);
        send(OP_NEXT, '0);
        send(OP_INS_HEAD, 32'h7fff_ffff);
        send(OP_INS_TAIL, 32'h8000_0000);
        send(OP_RD_TAIL, '0);
        send(OP_CUR_HEAD, '0);
        send(OP_INS_BEFORE, '1);
        send(OP_INS_AFTER, '0);
        send(OP_DEL_AFTER, '0);
        send(OP_DEL_BEFORE, '0);
        send(OP_WR_CUR, 32'h5a5a_a5a5);
        send(OP_RD_CUR, '0);
        send(OP_CUR_TAIL, '0);
        send(OP_NEXT, '0);
        send(OP_CUR_HEAD, '0);
        send(OP_PREV, '0);
        send(OP_CUR_HEAD, '0);
        send(OP_DEL_HEAD, '0);
        send(OP_SPARE_LO, 32'hffff_ffff);
        send(OP_SPARE_HI, 32'h8000_0001);
        send(OP_RD_HEAD, '0);
        send(OP_CLEAR, '0);
    endtask

    // Random run in phases of one operation mix each; now and then pause
    // the sender at a phase change until the core has drained.
    task automatic run_random();
        int              sent;
        int              phase_left;
        mix_t            mix;
        logic [OP_W-1:0] code;
        sent       = 0;
        phase_left = 0;
        mix        = MIX_GROW;
        while (sent < RANDOM_ITEMS)
        begin
            if (phase_left == 0)
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6: mix = MIX_GROW;
                    7, 8, 9, 10:         mix = MIX_SHRINK;
                    11, 12, 13, 14, 15:  mix = MIX_WALK;
                    default:             mix = MIX_NOISE;
                endcase
                phase_left = (mix == MIX_GROW) ? $urandom_range(40, 120) : $urandom_range(10, 80);
                if ($urandom_range(0, 9) == 0)
                    wait_quiet();
            end
            phase_left--;
            code = pick_op(mix);
            send(code, pick_word());
            sent++;
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        run_directed();
        // let the core drain completely once before the random run
        wait_quiet();
        run_random();
        wait_quiet();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && results_due == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
